@@ src/flcc_pkg.sv @@
// Shared types and constants for the frame luma change counter.
package flcc_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned LUMA_W     = 8;
  localparam int unsigned LUMA_SUM_W = 22;
  localparam int unsigned LUMA_SHIFT = 14;

  localparam logic [LUMA_SUM_W-1:0] LUMA_K0    = 22'd4899;
  localparam logic [LUMA_SUM_W-1:0] LUMA_K1    = 22'd9617;
  localparam logic [LUMA_SUM_W-1:0] LUMA_K2    = 22'd1868;
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 22'd8192;

  localparam int unsigned THR_W      = 8;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 10;
  localparam int unsigned DIM_PROD_W = WIDTH_W + HEIGHT_W;

  localparam int unsigned TALLY_W = 20;
  localparam int unsigned SHARE_W = 14;
  localparam int unsigned PROD_W  = 34;

  localparam logic [SHARE_W-1:0] SHARE_SCALE = 14'd10000;

  localparam logic [THR_W-1:0]    THR_RESET    = 8'd2;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd480;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_index_t;

endpackage

@@ src/flcc_pixel_if.sv @@
// Pixel stream channel: valid, ready and three colour channels.
interface flcc_pixel_if;
  import flcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel_zero;
  logic [CHAN_W-1:0] channel_one;
  logic [CHAN_W-1:0] channel_two;

  modport source (output valid, output channel_zero, output channel_one,
                  output channel_two, input ready);
  modport sink   (input valid, input channel_zero, input channel_one,
                  input channel_two, output ready);
endinterface

@@ src/flcc_result_if.sv @@
// Result channel: valid, ready, changed count and changed share.
interface flcc_result_if;
  import flcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TALLY_W-1:0] changed_count;
  logic [SHARE_W-1:0] changed_share;

  modport source (output valid, output changed_count, output changed_share, input ready);
  modport sink   (input valid, input changed_count, input changed_share, output ready);
endinterface

@@ src/frame_luma_change_counter.sv @@
// Frame luma change counter: top level with luma store, compare pipeline and result register.
//
// Takes one pixel per clock in raster order and keeps the luma of the last frame in a
// MAX_PIXELS x 8 single-port-write synchronous memory (read into a register as the pixel is
// taken, written back the cycle after, with forwarding when two pixels in a row hit the same
// position). The store has no clearing pass and needs none: the first frame after reset is only
// stored. At the end of each later frame the input stalls while the share unit runs through the
// launch, a multiply step, 34 one-bit divide steps and the handoff into the output register, and
// for longer if an earlier result has not been taken. Otherwise the rate is one pixel per cycle.
module frame_luma_change_counter #(
  parameter int unsigned MAX_PIXELS = 524288
) (
  input  logic                            clk,
  input  logic                            rst_n,
  flcc_pixel_if.sink                      in_pix,
  flcc_result_if.source                   out_res,
  input  logic                            cfg_we,
  input  logic [flcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import flcc_pkg::*;

  localparam int unsigned POS_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SIZE_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W  = (SIZE_W > DIM_PROD_W) ? SIZE_W : DIM_PROD_W;

  logic [THR_W-1:0]    thr_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  logic [LUMA_W-1:0]   luma_mem [MAX_PIXELS];

  logic [POS_W-1:0]    pos_r;
  logic                prev_frame_r;
  logic [TALLY_W-1:0]  tally_r;

  logic                p1_valid_r;
  logic [CHAN_W-1:0]   p1_c0_r;
  logic [CHAN_W-1:0]   p1_c1_r;
  logic [CHAN_W-1:0]   p1_c2_r;
  logic [POS_W-1:0]    p1_pos_r;
  logic                p1_end_r;
  logic                p1_prev_r;
  logic [SIZE_W-1:0]   p1_size_r;
  logic [LUMA_W-1:0]   rd_r;
  logic                fwd_r;
  logic [LUMA_W-1:0]   fwd_luma_r;

  logic                out_valid_r;
  logic [TALLY_W-1:0]  out_count_r;
  logic [SHARE_W-1:0]  out_share_r;

  logic [DIM_PROD_W-1:0] dim_prod;
  logic [CMP_W-1:0]      dim_ext;
  logic [SIZE_W-1:0]     frame_size;
  logic [SIZE_W-1:0]     pos_inc;
  logic                  frame_end;
  logic [POS_W-1:0]      pos_nxt;
  logic                  accept;

  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [LUMA_W-1:0]     luma;
  logic [LUMA_W-1:0]     prev_luma;
  logic [LUMA_W:0]       diff;
  logic                  changed;
  logic [TALLY_W-1:0]    tally_nxt;
  logic                  launch;

  logic                  div_busy;
  logic                  div_done;
  logic                  div_take;
  logic [TALLY_W-1:0]    div_count;
  logic [SHARE_W-1:0]    div_share;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        CFG_WIDTH:     width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT:    height_r <= cfg_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dim_prod = DIM_PROD_W'(width_r) * DIM_PROD_W'(height_r);
    dim_ext  = CMP_W'(dim_prod);
    if (dim_prod == '0) begin
      frame_size = SIZE_W'(1);
    end else if (dim_ext > CMP_W'(MAX_PIXELS)) begin
      frame_size = SIZE_W'(MAX_PIXELS);
    end else begin
      frame_size = SIZE_W'(dim_ext);
    end
    pos_inc   = SIZE_W'(pos_r) + SIZE_W'(1);
    frame_end = (pos_inc >= frame_size);
    pos_nxt   = frame_end ? '0 : POS_W'(pos_inc);
  end

  assign launch        = p1_valid_r && p1_end_r && p1_prev_r;
  assign in_pix.ready  = !div_busy && !launch;
  assign accept        = in_pix.valid && in_pix.ready;

  always_comb begin
    luma_sum = LUMA_SUM_W'(p1_c0_r) * LUMA_K0 + LUMA_SUM_W'(p1_c1_r) * LUMA_K1
             + LUMA_SUM_W'(p1_c2_r) * LUMA_K2 + LUMA_ROUND;
    luma      = luma_sum[LUMA_SHIFT +: LUMA_W];
    prev_luma = fwd_r ? fwd_luma_r : rd_r;
    diff      = {1'b0, prev_luma} - {1'b0, luma};
    changed   = p1_prev_r && !diff[LUMA_W] && (diff[LUMA_W-1:0] > thr_r);
    tally_nxt = (changed && (tally_r != '1)) ? tally_r + TALLY_W'(1) : tally_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= luma_mem[pos_r];
    end
    if (p1_valid_r) begin
      luma_mem[p1_pos_r] <= luma;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      prev_frame_r <= 1'b0;
      tally_r      <= '0;
      p1_valid_r   <= 1'b0;
    end else begin
      p1_valid_r <= accept;
      if (accept) begin
        pos_r <= pos_nxt;
        if (frame_end) begin
          prev_frame_r <= 1'b1;
        end
      end
      if (p1_valid_r) begin
        tally_r <= p1_end_r ? '0 : tally_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_c0_r    <= in_pix.channel_zero;
      p1_c1_r    <= in_pix.channel_one;
      p1_c2_r    <= in_pix.channel_two;
      p1_pos_r   <= pos_r;
      p1_end_r   <= frame_end;
      p1_prev_r  <= prev_frame_r;
      p1_size_r  <= frame_size;
      fwd_r      <= p1_valid_r && (p1_pos_r == pos_r);
      fwd_luma_r <= luma;
    end
  end

  flcc_share_div #(
    .SIZE_W (SIZE_W)
  ) u_share_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (launch),
    .tally     (tally_nxt),
    .size      (p1_size_r),
    .busy      (div_busy),
    .done      (div_done),
    .take      (div_take),
    .count_out (div_count),
    .share_out (div_share)
  );

  assign div_take = div_done && (!out_valid_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_take) begin
      out_valid_r <= 1'b1;
      out_count_r <= div_count;
      out_share_r <= div_share;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.changed_count = out_count_r;
  assign out_res.changed_share = out_share_r;

endmodule

@@ src/flcc_share_div.sv @@
// Changed-share unit: scale the tally by 10000, divide by frame size bit-serially, clamp.
module flcc_share_div #(
  parameter int unsigned SIZE_W = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [flcc_pkg::TALLY_W-1:0] tally,
  input  logic [SIZE_W-1:0]           size,
  output logic                        busy,
  output logic                        done,
  input  logic                        take,
  output logic [flcc_pkg::TALLY_W-1:0] count_out,
  output logic [flcc_pkg::SHARE_W-1:0] share_out
);
  import flcc_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [TALLY_W-1:0]  tally_r;
  logic [SIZE_W-1:0]   size_r;
  logic [PROD_W-1:0]   quo_r;
  logic [SIZE_W:0]     rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TALLY_W-1:0]  count_r;
  logic [SHARE_W-1:0]  share_r;

  logic [SIZE_W:0]     rem_sh;
  logic                q_bit;
  logic [SIZE_W:0]     rem_nxt;
  logic [PROD_W-1:0]   quo_nxt;

  always_comb begin
    rem_sh  = {rem_r[SIZE_W-1:0], quo_r[PROD_W-1]};
    q_bit   = (rem_sh >= {1'b0, size_r});
    rem_nxt = q_bit ? (rem_sh - {1'b0, size_r}) : rem_sh;
    quo_nxt = {quo_r[PROD_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            tally_r <= tally;
            size_r  <= size;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          quo_r   <= PROD_W'(tally_r) * PROD_W'(SHARE_SCALE);
          rem_r   <= '0;
          cnt_r   <= CNT_W'(PROD_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            count_r <= tally_r;
            share_r <= (quo_nxt > PROD_W'(SHARE_SCALE)) ? SHARE_SCALE
                                                         : quo_nxt[SHARE_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign done      = (state_r == S_DONE);
  assign count_out = count_r;
  assign share_out = share_r;

endmodule

@@ src/flcc_checker.sv @@
// Port-level checks for the frame luma change counter, bound to the top level.
module flcc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [flcc_pkg::TALLY_W-1:0] changed_count,
  input logic [flcc_pkg::SHARE_W-1:0] changed_share
);
  import flcc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(changed_count) && $stable(changed_share))
    else $error("stalled result changed");

  a_share_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> changed_share <= SHARE_SCALE)
    else $error("share above full scale");

  a_zero_count_zero_share: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && changed_count == '0 |-> changed_share == '0)
    else $error("nonzero share with zero count");

  a_no_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || $past(in_valid && in_ready) || !$past(in_ready))
    else $error("result follows result without a pixel");

endmodule

bind frame_luma_change_counter flcc_checker u_flcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_pix.valid),
  .in_ready      (in_pix.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .changed_count (out_res.changed_count),
  .changed_share (out_res.changed_share)
);
